// ===== rtl/wtre_pkg.sv =====
// Shared types and constants of the transfer rate and ETA estimator.
// Depends on nothing; every module of the block but wtre_div uses it.
package wtre_pkg;

  localparam int unsigned OFS_W  = 40;
  localparam int unsigned TIME_W = 48;
  localparam int unsigned KEY_W  = 64;
  localparam int unsigned WIN_W  = 16;
  localparam int unsigned PROG_W = 10;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_TRANSFER_KEY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MS    = 1'b1;

  localparam logic OP_UPDATE  = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  localparam logic [WIN_W-1:0] WINDOW_RESET = 16'd1000;
  localparam logic [9:0] PERMILLE = 10'd1000;

  typedef struct packed {
    logic              opcode;
    logic [KEY_W-1:0]  key;
    logic [OFS_W-1:0]  offset;
    logic [OFS_W-1:0]  length;
    logic [TIME_W-1:0] time_ms;
  } in_item_t;

  typedef struct packed {
    logic              rate_valid;
    logic [OFS_W-1:0]  bytes_per_sec;
    logic [OFS_W-1:0]  eta_seconds;
    logic [PROG_W-1:0] progress_permille;
  } out_item_t;

  // Divider operation selected by the controller.
  typedef enum logic [1:0] {
    DIV_RATE = 2'd0,
    DIV_ETA  = 2'd1,
    DIV_PROG = 2'd2
  } div_sel_t;

  typedef struct packed {
    logic     load;      // capture input item
    logic     clr_start; // begin clearing pass
    logic     clr_step;  // clear one entry
    logic     store;     // write record at head
    logic     scan_rd;   // issue history read at scan index
    logic     scan_eval; // test read data against window
    logic     div_start;
    div_sel_t div_sel;
    logic     div_take;  // capture divider result
    logic     out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic key_match;
    logic opcode_restart;
    logic clr_done;
    logic scan_hit;   // current record qualifies
    logic scan_last;  // scan index reached last candidate
    logic div_busy;
    logic rate_zero;
    logic eta_skip;
    logic prog_skip;
  } ctl_status_t;

endpackage

// ===== rtl/wtre_div.sv =====
// Restoring divider, one quotient bit per cycle, full quotient width.
// Depends on nothing; the operand widths come in as parameters.
module wtre_div #(
  parameter int unsigned NUM_W = 50,
  parameter int unsigned DEN_W = 48
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic [NUM_W-1:0] quot
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] q;
  logic [DEN_W:0]   rem;
  logic [DEN_W-1:0] d;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W:0]   trial;

  assign trial = {rem[DEN_W-1:0], q[NUM_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(NUM_W);
      q    <= num;
      rem  <= '0;
      d    <= den;
    end else if (busy) begin
      if (trial >= {1'b0, d}) begin
        rem <= trial - {1'b0, d};
        q   <= {q[NUM_W-2:0], 1'b1};
      end else begin
        rem <= trial;
        q   <= {q[NUM_W-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign quot = q;

endmodule

// ===== rtl/wtre_datapath.sv =====
// Datapath: history memory, configuration, scan pointer, divider operands, output register.
// Depends on wtre_pkg and wtre_div.
module wtre_datapath #(
  parameter int unsigned DEPTH = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [wtre_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wtre_pkg::KEY_W-1:0]    cfg_data,
  input  wtre_pkg::in_item_t            in_data,
  input  wtre_pkg::ctl_cmd_t            cmd,
  output wtre_pkg::ctl_status_t         status,
  output wtre_pkg::out_item_t           out_data
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned NUM_W = wtre_pkg::OFS_W + 10;
  localparam int unsigned DEN_W = wtre_pkg::TIME_W;
  localparam logic [AW:0] LAST_K = (AW+1)'(DEPTH);

  logic [wtre_pkg::KEY_W-1:0] transfer_key;
  logic [wtre_pkg::WIN_W-1:0] window_ms;
  wtre_pkg::in_item_t item;

  logic [wtre_pkg::OFS_W-1:0]  mem_ofs [DEPTH];
  logic [wtre_pkg::TIME_W-1:0] mem_time [DEPTH];
  logic [wtre_pkg::OFS_W-1:0]  rd_ofs;
  logic [wtre_pkg::TIME_W-1:0] rd_time;

  logic [AW-1:0] head_ptr;
  logic [AW:0]   clr_cnt;
  logic [AW:0]   k;
  logic [AW-1:0] rd_addr;
  logic [AW:0]   idx_ext;
  logic [AW-1:0] idx;

  logic [wtre_pkg::OFS_W-1:0]  ref_ofs;
  logic [wtre_pkg::TIME_W-1:0] ref_time;
  logic [wtre_pkg::OFS_W-1:0]  rate;
  logic [wtre_pkg::OFS_W-1:0]  eta;
  logic [wtre_pkg::PROG_W-1:0] prog;

  logic [NUM_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;
  logic [NUM_W-1:0] div_q;
  logic             div_busy;

  logic [wtre_pkg::TIME_W:0]  win_sum;
  logic [wtre_pkg::OFS_W-1:0] bytes;
  logic [wtre_pkg::TIME_W-1:0] spent;
  logic                        hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      transfer_key <= '0;
      window_ms    <= wtre_pkg::WINDOW_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        wtre_pkg::REG_TRANSFER_KEY: transfer_key <= cfg_data;
        wtre_pkg::REG_WINDOW_MS:    window_ms <= cfg_data[wtre_pkg::WIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= in_data;
    end
  end

  // Scan index: k-th record back from the newest, k from 1, modulo the depth.
  assign idx_ext = ({1'b0, head_ptr} >= k) ? {1'b0, head_ptr} - k
                                           : {1'b0, head_ptr} + LAST_K - k;
  assign idx = idx_ext[AW-1:0];
  assign rd_addr = idx;

  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      mem_ofs[clr_cnt[AW-1:0]]  <= '0;
      mem_time[clr_cnt[AW-1:0]] <= '0;
    end else if (cmd.store) begin
      mem_ofs[head_ptr]  <= item.offset;
      mem_time[head_ptr] <= item.time_ms;
    end
    rd_ofs  <= mem_ofs[rd_addr];
    rd_time <= mem_time[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_ptr <= '0;
      clr_cnt  <= '0;
      k        <= '0;
    end else begin
      if (cmd.clr_start) begin
        clr_cnt  <= '0;
        head_ptr <= '0;
      end else if (cmd.clr_step) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (cmd.store) begin
        head_ptr <= (head_ptr == AW'(DEPTH - 1)) ? '0 : head_ptr + 1'b1;
        k        <= (AW+1)'(1);
      end else if (cmd.scan_eval && !hit) begin
        k <= k + 1'b1;
      end
    end
  end

  assign win_sum = {1'b0, rd_time} + (wtre_pkg::TIME_W+1)'(window_ms);
  assign hit = ({1'b0, item.time_ms} >= win_sum);

  // The reference register follows the last record read, so a miss on the
  // final candidate leaves it at the oldest slot, read once more below.
  always_ff @(posedge clk) begin
    if (cmd.scan_eval) begin
      ref_ofs  <= rd_ofs;
      ref_time <= rd_time;
    end
  end

  assign spent = (ref_time != '0 && item.time_ms > ref_time) ? item.time_ms - ref_time : '0;
  assign bytes = (item.offset > ref_ofs) ? item.offset - ref_ofs : '0;

  always_comb begin
    div_num = '0;
    div_den = '0;
    case (cmd.div_sel)
      wtre_pkg::DIV_RATE: begin
        div_num = (NUM_W)'(bytes) * (NUM_W)'(1000);
        div_den = spent;
      end
      wtre_pkg::DIV_ETA: begin
        div_num = (NUM_W)'(item.length - item.offset);
        div_den = DEN_W'(rate);
      end
      wtre_pkg::DIV_PROG: begin
        div_num = (NUM_W)'(item.offset) * (NUM_W)'(1000);
        div_den = DEN_W'(item.length);
      end
      default: ;
    endcase
  end

  wtre_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quot  (div_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      rate <= '0;
      eta  <= '0;
      prog <= '0;
    end else if (cmd.div_take) begin
      case (cmd.div_sel)
        wtre_pkg::DIV_RATE:
          rate <= (div_q > NUM_W'({wtre_pkg::OFS_W{1'b1}})) ? '1 : div_q[wtre_pkg::OFS_W-1:0];
        wtre_pkg::DIV_ETA:
          eta <= div_q[wtre_pkg::OFS_W-1:0];
        wtre_pkg::DIV_PROG:
          prog <= (div_q > NUM_W'(wtre_pkg::PERMILLE)) ? wtre_pkg::PERMILLE
                                                      : div_q[wtre_pkg::PROG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.rate_valid        <= (rate != '0);
      out_data.bytes_per_sec     <= rate;
      out_data.eta_seconds       <= eta;
      out_data.progress_permille <= prog;
    end
  end

  always_comb begin
    status.key_match      = (in_data.key == transfer_key);
    status.opcode_restart = (in_data.opcode == wtre_pkg::OP_RESTART);
    status.clr_done       = (clr_cnt == (AW+1)'(DEPTH - 1));
    status.scan_hit       = hit;
    status.scan_last      = (k >= LAST_K);
    status.div_busy       = div_busy;
    status.rate_zero      = (spent == '0);
    status.eta_skip       = (rate == '0) || !(item.length > item.offset);
    status.prog_skip      = (item.length == '0);
  end

endmodule

// ===== rtl/wtre_ctrl.sv =====
// Controller state machine sequencing clear, store, scan and the three divisions.
// Depends on wtre_pkg.
module wtre_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  wtre_pkg::ctl_status_t status,
  output wtre_pkg::ctl_cmd_t    cmd
);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_CLEAR  = 11'b00000000010,
    S_STORE  = 11'b00000000100,
    S_READ   = 11'b00000001000,
    S_EVAL   = 11'b00000010000,
    S_RATE   = 11'b00000100000,
    S_ETA    = 11'b00001000000,
    S_PROG   = 11'b00010000000,
    S_DWAIT  = 11'b00100000000,
    S_OUT    = 11'b01000000000,
    S_HOLD   = 11'b10000000000
  } state_t;

  state_t state, state_next;
  wtre_pkg::div_sel_t sel, sel_next;
  logic accept;

  assign in_ready  = (state == S_IDLE) || (state == S_HOLD && out_ready);
  assign accept    = in_valid && in_ready;
  assign out_valid = (state == S_HOLD);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      sel   <= wtre_pkg::DIV_RATE;
    end else begin
      state <= state_next;
      sel   <= sel_next;
    end
  end

  always_comb begin
    state_next = state;
    sel_next   = sel;
    cmd        = '0;
    cmd.div_sel = sel;
    if (rst) begin
      cmd.clr_start = 1'b1;
    end
    case (state)
      S_IDLE, S_HOLD: begin
        if (state == S_HOLD && out_ready) begin
          state_next = S_IDLE;
        end
        if (accept) begin
          cmd.load = 1'b1;
          if (status.opcode_restart) begin
            cmd.clr_start = 1'b1;
            state_next = S_CLEAR;
          end else if (status.key_match) begin
            state_next = S_STORE;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (status.clr_done) begin
          state_next = S_IDLE;
        end
      end
      S_STORE: begin
        cmd.store  = 1'b1;
        state_next = S_READ;
      end
      S_READ: begin
        cmd.scan_rd = 1'b1;
        state_next  = S_EVAL;
      end
      S_EVAL: begin
        cmd.scan_eval = 1'b1;
        if (status.scan_hit || status.scan_last) begin
          state_next = S_RATE;
        end else begin
          state_next = S_READ;
        end
      end
      S_RATE: begin
        sel_next = wtre_pkg::DIV_RATE;
        cmd.div_sel = wtre_pkg::DIV_RATE;
        if (status.rate_zero) begin
          state_next = S_ETA;
        end else begin
          cmd.div_start = 1'b1;
          state_next = S_DWAIT;
        end
      end
      S_ETA: begin
        sel_next = wtre_pkg::DIV_ETA;
        cmd.div_sel = wtre_pkg::DIV_ETA;
        if (status.eta_skip) begin
          state_next = S_PROG;
        end else begin
          cmd.div_start = 1'b1;
          state_next = S_DWAIT;
        end
      end
      S_PROG: begin
        sel_next = wtre_pkg::DIV_PROG;
        cmd.div_sel = wtre_pkg::DIV_PROG;
        if (status.prog_skip) begin
          state_next = S_OUT;
        end else begin
          cmd.div_start = 1'b1;
          state_next = S_DWAIT;
        end
      end
      S_DWAIT: begin
        if (!status.div_busy) begin
          cmd.div_take = 1'b1;
          case (sel)
            wtre_pkg::DIV_RATE: state_next = S_ETA;
            wtre_pkg::DIV_ETA:  state_next = S_PROG;
            default:            state_next = S_OUT;
          endcase
        end
      end
      S_OUT: begin
        cmd.out_load = 1'b1;
        state_next = S_HOLD;
      end
      default: state_next = S_IDLE;
    endcase
  end

  a_hold_stable: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !in_ready)
    else $error("input taken during clearing pass");
  a_single_div: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !status.div_busy)
    else $error("divider started while busy");

endmodule

// ===== rtl/windowed_transfer_rate_eta.sv =====
// Top level of the windowed transfer rate and ETA estimator.
// Depends on wtre_pkg, wtre_ctrl and wtre_datapath.
//
// The in channel carries one transaction per update or restart; the out
// channel carries one result per update whose key matches transfer_key.
// A restart or a mismatched update gives no result. Configuration is a plain
// write port (cfg_we, cfg_index, cfg_data), to be used while the block is
// idle; the user is bound to this and the block itself does not enforce it.
// An update examines up to HISTORY_DEPTH records, with one memory read and
// one window test per record and the oldest slot last, then runs up to
// three serial divisions in a one-bit-per-cycle divider; a division may
// be skipped. The result waits in an output register until taken; a new
// transaction is accepted in the same cycle the result leaves. After reset,
// and after each restart, a clearing pass zeroes the history memory; no
// transaction is accepted during it. Reset sets transfer_key to 0 and
// window_ms to 1000.
module windowed_transfer_rate_eta #(
  parameter int unsigned HISTORY_DEPTH = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  wtre_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output wtre_pkg::out_item_t            out_data,
  input  logic                           cfg_we,
  input  logic [wtre_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wtre_pkg::KEY_W-1:0]     cfg_data
);

  wtre_pkg::ctl_cmd_t    cmd;
  wtre_pkg::ctl_status_t status;

  wtre_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  wtre_datapath #(.DEPTH(HISTORY_DEPTH)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

endmodule

// ===== tb/rate_eta_checker.sv =====
// Checker for the transfer rate and ETA estimator: mirrors the history ring,
// predicts each estimate and compares it with the out channel.
// Depends on wtre_pkg; instantiated beside the block by tb.
module rate_eta_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  wtre_pkg::in_item_t             in_data,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  wtre_pkg::out_item_t            out_data,
  input  logic                           cfg_we,
  input  logic [wtre_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wtre_pkg::KEY_W-1:0]     cfg_data,
  output int                             errors,
  output int                             pending,
  output int                             estimates_seen
);
  import wtre_pkg::*;

  localparam int DEPTH = 256;
  localparam logic [63:0] MAX40 = 64'hFF_FFFF_FFFF;

  logic [KEY_W-1:0]  key_reg;
  logic [WIN_W-1:0]  win_reg;
  logic [OFS_W-1:0]  ring_ofs [DEPTH];
  logic [TIME_W-1:0] ring_time [DEPTH];
  logic [7:0]        head;
  out_item_t         expected_estimates [$];

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic clear_ring();
    for (int i = 0; i < DEPTH; i++) begin
      ring_ofs[i] = '0;
      ring_time[i] = '0;
    end
    head = '0;
  endtask

  function automatic out_item_t estimate(input in_item_t it);
    out_item_t   res;
    logic [7:0]  ref_idx;
    logic [7:0]  idx;
    logic [63:0] now, spent, bytes, rate, eta, prog;
    bit          found;
    now = 64'(it.time_ms);
    ring_ofs[head] = it.offset;
    ring_time[head] = it.time_ms;
    head = head + 8'd1;
    ref_idx = head;
    found = 0;
    for (int k = 1; k < DEPTH; k++) begin
      idx = head - 8'(k);
      if (!found && now >= 64'(ring_time[idx]) + 64'(win_reg)) begin
        ref_idx = idx;
        found = 1;
      end
    end
    spent = 0;
    if (ring_time[ref_idx] != 0 && now > 64'(ring_time[ref_idx]))
      spent = now - 64'(ring_time[ref_idx]);
    bytes = (it.offset > ring_ofs[ref_idx]) ? 64'(it.offset) - 64'(ring_ofs[ref_idx]) : 0;
    rate = 0;
    if (spent != 0) begin
      rate = bytes * 1000 / spent;
      if (rate > MAX40) rate = MAX40;
    end
    eta = 0;
    if (rate != 0 && it.length > it.offset)
      eta = (64'(it.length) - 64'(it.offset)) / rate;
    prog = 0;
    if (it.length != 0) begin
      prog = 64'(it.offset) * 1000 / 64'(it.length);
      if (prog > 1000) prog = 1000;
    end
    res.rate_valid = (rate != 0);
    res.bytes_per_sec = rate[OFS_W-1:0];
    res.eta_seconds = eta[OFS_W-1:0];
    res.progress_permille = prog[PROG_W-1:0];
    return res;
  endfunction

  initial begin
    errors = 0;
    estimates_seen = 0;
  end

  assign pending = expected_estimates.size();

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      key_reg = '0;
      win_reg = WINDOW_RESET;
      clear_ring();
      expected_estimates.delete();
    end else begin
      if (out_valid && out_ready) begin
        estimates_seen++;
        if (expected_estimates.size() == 0) begin
          report("unexpected transaction", 64'(out_data.bytes_per_sec), 0);
        end else begin
          want = expected_estimates.pop_front();
          if (out_data.rate_valid !== want.rate_valid)
            report("rate_valid", 64'(out_data.rate_valid), 64'(want.rate_valid));
          if (out_data.bytes_per_sec !== want.bytes_per_sec)
            report("bytes_per_sec", 64'(out_data.bytes_per_sec), 64'(want.bytes_per_sec));
          if (out_data.eta_seconds !== want.eta_seconds)
            report("eta_seconds", 64'(out_data.eta_seconds), 64'(want.eta_seconds));
          if (out_data.progress_permille !== want.progress_permille)
            report("progress_permille", 64'(out_data.progress_permille),
                   64'(want.progress_permille));
        end
      end
      if (in_valid && in_ready) begin
        if (in_data.opcode == OP_RESTART)
          clear_ring();
        else if (in_data.key == key_reg)
          expected_estimates.push_back(estimate(in_data));
      end
      if (cfg_we) begin
        if (cfg_index == REG_TRANSFER_KEY)
          key_reg = cfg_data;
        else if (cfg_index == REG_WINDOW_MS)
          win_reg = cfg_data[WIN_W-1:0];
      end
    end
  end
endmodule

// ===== tb/tb.sv =====
// Top of the estimator testbench: clock, reset, stimulus and verdict.
// Depends on wtre_pkg, windowed_transfer_rate_eta and rate_eta_checker.
module tb;
  import wtre_pkg::*;

  localparam logic [63:0] MAX40 = 64'hFF_FFFF_FFFF;
  localparam logic [63:0] MAX48 = 64'hFFFF_FFFF_FFFF;
  localparam int SETTLE = 800;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 0;
  out_item_t out_data;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_TRANSFER_KEY;
  logic [KEY_W-1:0] cfg_data = '0;
  int errors, pending, estimates_seen;
  int burst_left = 0;
  int stall_pct = 0;
  int updates_sent = 0;
  int restarts_sent = 0;
  logic [KEY_W-1:0] cur_key = '0;
  logic [WIN_W-1:0] cur_win = WINDOW_RESET;

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  windowed_transfer_rate_eta dut (
    .clk, .rst, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .cfg_we, .cfg_index, .cfg_data
  );

  rate_eta_checker checker_i (
    .clk, .rst, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .cfg_we, .cfg_index, .cfg_data, .errors, .pending, .estimates_seen
  );

  always @(negedge clk) begin
    if ($urandom_range(0, 299) == 0)
      stall_pct <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 90);
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  function automatic in_item_t mk(input logic op, input logic [63:0] k,
                                  input logic [63:0] ofs, input logic [63:0] len,
                                  input logic [63:0] t);
    in_item_t it;
    it.opcode = op;
    it.key = k;
    it.offset = ofs[OFS_W-1:0];
    it.length = len[OFS_W-1:0];
    it.time_ms = t[TIME_W-1:0];
    return it;
  endfunction

  task automatic send(input in_item_t it);
    if (it.opcode == OP_RESTART) restarts_sent++;
    else updates_sent++;
    in_data = it;
    in_valid = 1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid = 0;
      repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 30)) @(negedge clk);
      burst_left = $urandom_range(0, 12);
    end
  endtask

  task automatic settle();
    in_valid = 0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [KEY_W-1:0] val);
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 0;
    if (idx == REG_TRANSFER_KEY) cur_key = val;
    else cur_win = val[WIN_W-1:0];
  endtask

  task automatic run_sequence(input int n);
    logic [63:0] t, ofs, len, step;
    t = ($urandom_range(0, 3) == 0) ? {$urandom(), $urandom()} & (MAX48 >> 2)
                                     : 64'($urandom_range(1, 5000));
    ofs = 64'($urandom_range(0, 100000));
    len = ($urandom_range(0, 5) == 0) ? 0 : {$urandom(), $urandom()} & MAX40;
    if ($urandom_range(0, 4) != 0) send(mk(OP_RESTART, {$urandom(), $urandom()}, 0, 0, 0));
    for (int i = 0; i < n; i++) begin
      step = 64'($urandom_range(0, 2 * int'(cur_win) + 2));
      t = t + step;
      ofs = ofs + 64'($urandom_range(0, 2000000));
      if ($urandom_range(0, 19) == 0) ofs = {$urandom(), $urandom()} & MAX40;
      case ($urandom_range(0, 19))
        0: send(mk(OP_UPDATE, {$urandom(), $urandom()}, ofs, len, t));
        1: send(mk(OP_UPDATE, cur_key, ofs, len, 0));
        2: send(mk($urandom_range(0, 1), {$urandom(), $urandom()},
                   {$urandom(), $urandom()}, {$urandom(), $urandom()},
                   {$urandom(), $urandom()}));
        default: send(mk(OP_UPDATE, cur_key, ofs & MAX40, len, t & MAX48));
      endcase
    end
  endtask

  initial begin
    logic [WIN_W-1:0] wins [5];
    logic [KEY_W-1:0] keys [5];
    wins = '{16'd1000, 16'd1, 16'd65535, 16'd0, 16'd0};
    keys = '{64'd0, '1, 64'd0, 64'd0, 64'd0};
    repeat (5) @(negedge clk);
    rst = 0;

    // Directed: empty records, zero time, going backward, overshoot, saturation.
    send(mk(OP_RESTART, 0, 0, 0, 0));
    send(mk(OP_UPDATE, 0, 5, 10, 0));
    send(mk(OP_UPDATE, 0, 0, 0, 1));
    send(mk(OP_UPDATE, 0, 1000, 4000, 500));
    send(mk(OP_UPDATE, 0, 2000, 4000, 1500));
    send(mk(OP_UPDATE, 0, 3000, 4000, 1500));
    send(mk(OP_UPDATE, 0, 1000, 4000, 3000));
    send(mk(OP_UPDATE, 0, 9000, 4000, 5000));
    send(mk(OP_UPDATE, '1, 9000, 4000, 6000));
    send(mk(OP_UPDATE, 0, MAX40, MAX40, 7000));
    send(mk(OP_UPDATE, 0, MAX40, 0, MAX48));
    send(mk(OP_UPDATE, 0, 0, MAX40, MAX48));
    settle();
    write_reg(REG_WINDOW_MS, 64'd1);
    send(mk(OP_RESTART, '1, MAX40, MAX40, MAX48));
    send(mk(OP_UPDATE, 0, 0, MAX40, 1));
    send(mk(OP_UPDATE, 0, MAX40, MAX40, 2));
    send(mk(OP_UPDATE, 0, MAX40 - 1, MAX40, 2));
    send(mk(OP_UPDATE, 0, 1, 3, 3));
    settle();

    for (int p = 0; p < 5; p++) begin
      write_reg(REG_TRANSFER_KEY, (p < 2) ? keys[p] : {$urandom(), $urandom()});
      write_reg(REG_WINDOW_MS, (p < 3) ? 64'(wins[p]) : 64'($urandom_range(1, 65535)));
      if (p == 1) run_sequence(280);
      while (updates_sent + restarts_sent < 150 * (p + 1) + 20)
        run_sequence($urandom_range(3, 40));
      settle();
    end

    $display("Sent %0d updates and %0d restarts over several key and window settings;",
             updates_sent, restarts_sent);
    $display("%0d estimates were compared.", estimates_seen);
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #(12 * 6000000);
    $display("DONE: errors detected");
    $finish;
  end
endmodule
